[sv/hpm_pkg.sv]
// Shared types and constants for the Horner evaluator mod p.
// Used by hpm_ctrl, hpm_datapath and horner_poly_eval_mod_p_core; no dependencies.
package hpm_pkg;

   localparam int WORD_BITS  = 32;
   localparam int COEFF_BITS = 32;
   localparam int STEP_BITS  = $clog2(WORD_BITS);

   localparam logic [WORD_BITS-1:0] CoeffMask = (COEFF_BITS >= WORD_BITS) ? '1 :
      WORD_BITS'((64'd1 << COEFF_BITS) - 64'd1);
   localparam logic [WORD_BITS-1:0] PrimeReset = WORD_BITS'(2);
   localparam logic [STEP_BITS-1:0] LastStep   = STEP_BITS'(WORD_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_FIXUP,
      ST_COMMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      OP_FIRST,
      OP_FIX,
      OP_MAC
   } op_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic step;
      logic fixup;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic last;
      logic run_done;
      logic fix_pass;
      logic out_free;
   } dp_status_type;

endpackage

[sv/hpm_ctrl.sv]
// Sequencer for the Horner evaluator: accept, load, serial run, fixup, commit.
// Depends on hpm_pkg.
module hpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  hpm_pkg::dp_status_type status,
   output hpm_pkg::ctrl_cmd_type  cmd
);
   import hpm_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = status.mod_zero ? ST_COMMIT : ST_RUN;
         end
         ST_RUN: begin
            if (status.run_done) state_in = status.fix_pass ? ST_FIXUP : ST_COMMIT;
         end
         ST_FIXUP: begin
            state_in = ST_LOAD;
         end
         ST_COMMIT: begin
            if (!status.last || status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_LOAD: begin
            cmd.start = !status.mod_zero;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
         end
         ST_FIXUP: begin
            cmd.fixup = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = !status.last || status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/hpm_datapath.sv]
// Datapath: modulus register, Horner state, two bit-serial mod-p units, result register.
// Depends on hpm_pkg; driven by hpm_ctrl commands.
module hpm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [hpm_pkg::WORD_BITS-1:0]        csr_data,
   input  logic [hpm_pkg::WORD_BITS-1:0]        in_coefficient,
   input  logic [hpm_pkg::WORD_BITS-1:0]        in_eval_point,
   input  logic                                 in_first,
   input  logic                                 in_last,
   input  hpm_pkg::ctrl_cmd_type                cmd,
   output hpm_pkg::dp_status_type               status,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [hpm_pkg::WORD_BITS-1:0]        rsp_result,
   output logic                                 rsp_error
);
   import hpm_pkg::*;

   logic [WORD_BITS-1:0] prime_ff;
   logic                 stale_ff;
   logic [WORD_BITS-1:0] acc_ff, held_ff;
   logic [WORD_BITS-1:0] coef_ff, point_ff;
   logic                 first_ff, last_ff;
   op_type               op_ff;
   logic [WORD_BITS-1:0] ma_ff, mb_ff, cs_ff;
   logic [WORD_BITS-1:0] rm_ff, rc_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_result_ff;
   logic                 rsp_error_ff;

   logic [WORD_BITS+1:0] m_sum, m_red1, m_red2, p_ext2;
   logic [WORD_BITS:0]   c_sum, c_red, p_ext1, s_sum, s_red;
   logic [WORD_BITS-1:0] rm_in, rc_in, acc_in;
   logic                 mod_zero;
   logic                 rsp_valid_in;
   logic                 stale_in;

   assign mod_zero = (prime_ff == '0);
   assign p_ext2   = {2'b00, prime_ff};
   assign p_ext1   = {1'b0, prime_ff};

   // Multiplier step: r = (2r + bit*a) mod p, with a below p (or a one for reduction).
   always_comb begin
      m_sum  = {1'b0, rm_ff, 1'b0} + (mb_ff[WORD_BITS-1] ? {2'b00, ma_ff} : '0);
      m_red1 = (m_sum >= p_ext2) ? m_sum - p_ext2 : m_sum;
      m_red2 = (m_red1 >= p_ext2) ? m_red1 - p_ext2 : m_red1;
      rm_in  = m_red2[WORD_BITS-1:0];
   end

   // Reduction step: r = (2r + bit) mod p.
   always_comb begin
      c_sum = {rc_ff, cs_ff[WORD_BITS-1]};
      c_red = (c_sum >= p_ext1) ? c_sum - p_ext1 : c_sum;
      rc_in = c_red[WORD_BITS-1:0];
   end

   // Final add of product and reduced coefficient.
   always_comb begin
      s_sum  = {1'b0, rm_ff} + {1'b0, rc_ff};
      s_red  = (s_sum >= p_ext1) ? s_sum - p_ext1 : s_sum;
      acc_in = first_ff ? rc_ff : s_red[WORD_BITS-1:0];
   end

   // Result valid: drop on a taken transaction, raise on a committed last item.
   // Stale flag: raise on a modulus write, drop once the state is reduced again.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.commit && last_ff) rsp_valid_in = 1'b1;
      stale_in = stale_ff;
      if (cmd.fixup || cmd.commit) stale_in = 1'b0;
      if (csr_valid) stale_in = 1'b1;
   end

   always_comb begin
      status.mod_zero = mod_zero;
      status.last     = last_ff;
      status.run_done = (cnt_ff == LastStep);
      status.fix_pass = (op_ff == OP_FIX);
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff     <= PrimeReset;
         stale_ff     <= 1'b0;
         acc_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) prime_ff <= csr_data;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.fixup) begin
            acc_ff  <= rc_ff;
            held_ff <= rm_ff;
         end
         if (cmd.commit) begin
            if (mod_zero) begin
               acc_ff  <= '0;
               held_ff <= '0;
            end else begin
               acc_ff <= acc_in;
               if (first_ff) held_ff <= rm_ff;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         coef_ff  <= in_coefficient & CoeffMask;
         point_ff <= in_eval_point;
         first_ff <= in_first;
         last_ff  <= in_last;
      end
      if (cmd.start) begin
         rm_ff  <= '0;
         rc_ff  <= '0;
         cnt_ff <= '0;
         if (first_ff) begin
            op_ff <= OP_FIRST;
            ma_ff <= WORD_BITS'(1);
            mb_ff <= point_ff;
            cs_ff <= coef_ff;
         end else if (stale_ff) begin
            op_ff <= OP_FIX;
            ma_ff <= WORD_BITS'(1);
            mb_ff <= held_ff;
            cs_ff <= acc_ff;
         end else begin
            op_ff <= OP_MAC;
            ma_ff <= acc_ff;
            mb_ff <= held_ff;
            cs_ff <= coef_ff;
         end
      end
      if (cmd.step) begin
         rm_ff  <= rm_in;
         rc_ff  <= rc_in;
         mb_ff  <= {mb_ff[WORD_BITS-2:0], 1'b0};
         cs_ff  <= {cs_ff[WORD_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff + STEP_BITS'(1);
      end
      if (cmd.commit && last_ff) begin
         rsp_result_ff <= mod_zero ? '0 : acc_in;
         rsp_error_ff  <= mod_zero;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_error  = rsp_error_ff;

endmodule

[sv/horner_poly_eval_mod_p_core.sv]
// Top level of the Horner polynomial evaluator over Z/pZ.
// Depends on hpm_pkg, hpm_ctrl and hpm_datapath.
//
// Usage: write the prime modulus p on the csr_ channel while the block is idle
// (reset value 2). Stream coefficients on req_, highest degree first: the item
// with req_tuser high starts an evaluation and latches the point, the item with
// req_tlast high is the constant term and yields one transaction on rsp_.
// Each item runs through a bit-serial shift-add modular multiplier and a
// bit-serial reducer side by side, one bit per cycle, so a new item is
// accepted only once the last has passed accept, load, the steps and commit.
// After a modulus write the first non-leading item spends one extra pass
// (serial steps, fixup, reload) re-reducing the stored accumulator and point.
// The result is registered: rsp_tvalid rises the cycle after commit and
// holds until rsp_tready. A new item is accepted while a result waits; only
// a later last item stalls in commit until the pending result is taken.
// A zero modulus clears the state and gives result 0 with rsp_tuser high.
// Reset sets p to 2, clears accumulator and point, and drops rsp_tvalid.
module horner_poly_eval_mod_p_core (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration: prime modulus
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpm_pkg::WORD_BITS-1:0]       csr_data,
   // Coefficient stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*hpm_pkg::WORD_BITS-1:0]     req_tdata,  // [31:0] coefficient, [63:32] eval_point
   input  logic                                req_tuser,  // first_coeff
   input  logic                                req_tlast,  // last_coeff
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hpm_pkg::WORD_BITS-1:0]       rsp_tdata,  // [31:0] eval_result
   output logic                                rsp_tuser   // modulus_error
);
   import hpm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Modulus writes are for the user to make only while idle; the block does not enforce this and always takes them.
   assign csr_ready = 1'b1;

   hpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hpm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .in_coefficient (req_tdata[WORD_BITS-1:0]),
      .in_eval_point  (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .in_first       (req_tuser),
      .in_last        (req_tlast),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_result     (rsp_tdata),
      .rsp_error      (rsp_tuser)
   );

endmodule
